### rtl/thermistor_temperature_averager_top_macros.svh
// assertion macros for the thermistor temperature averager checker
// expects signals clk and rst_n in the scope where the macros are used
`ifndef THERMISTOR_TEMPERATURE_AVERAGER_TOP_MACROS_SVH
`define THERMISTOR_TEMPERATURE_AVERAGER_TOP_MACROS_SVH

// implication checked every clock outside reset
`define TTA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the next cycle
`define TTA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tta_pkg.sv
// shared types and constants of the thermistor temperature averager
// no dependencies; imported by every module of the block
package tta_pkg;

    localparam int SUM_WIDTH   = 48;
    localparam int COUNT_WIDTH = 32;

    localparam int DVD_W = 64;
    localparam int DVS_W = 48;

    localparam logic [29:0] LN2_Q30       = 30'd744261118;
    localparam logic [14:0] KELVIN_OFFSET = 15'd27315;
    localparam logic signed [15:0] T_MAX  = 16'sd32767;
    localparam logic signed [15:0] T_MIN  = -16'sd32768;

    typedef enum logic [2:0] {
        REG_DIVIDER_OHMS = 3'd0,
        REG_NOMINAL_OHMS = 3'd1,
        REG_BETA_KELVIN  = 3'd2,
        REG_NOMINAL_TEMP = 3'd3,
        REG_SUPPLY_MV    = 3'd4,
        REG_CALIB_OFFSET = 3'd5,
        REG_UPPER_LIMIT  = 3'd6,
        REG_LOWER_LIMIT  = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [12:0] probe_mv;
        logic [12:0] therm_mv;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] probe_avg_centic;
        logic signed [15:0] therm_avg_centic;
        logic               bad_temp;
        logic               sample_fault;
    } result_t;

    // configuration as seen by the datapath, zero in a scale field already read as one
    typedef struct packed {
        logic [19:0]        divider_ohms;
        logic [19:0]        nominal_ohms;
        logic [13:0]        beta_kelvin;
        logic [15:0]        nominal_temp_centik;
        logic [12:0]        supply_mv;
        logic signed [13:0] calib_offset_centic;
        logic signed [15:0] upper_limit_centic;
        logic signed [15:0] lower_limit_centic;
    } cfg_t;

    // handshake between the output register and the sequencer
    typedef struct packed {
        logic start;
        logic res_free;
    } core_ctl_t;

endpackage

### rtl/tta_div.sv
// restoring divider, one quotient bit per cycle
// depends on tta_pkg for operand widths
module tta_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [tta_pkg::DVD_W-1:0] dividend,
    input  logic [tta_pkg::DVS_W-1:0] divisor,
    output logic                     done,
    output logic [tta_pkg::DVD_W-1:0] quotient
);
    import tta_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic [DVD_W-1:0]   q_reg, q_next;
    logic [DVS_W-1:0]   rem_reg, rem_next;
    logic [DVS_W-1:0]   dvs_reg, dvs_next;
    logic [DVS_W:0]     trial;

    // one shift and trial subtract per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, q_reg[DVD_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DVS_W'(trial - {1'b0, dvs_reg});
                q_next   = {q_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DVS_W-1:0];
                q_next   = {q_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### rtl/tta_core.sv
// sequencer with one shared multiplier: log2, Beta equation, sums and means
// depends on tta_pkg and tta_div
module tta_core (
    input  logic               clk,
    input  logic               rst_n,
    input  tta_pkg::core_ctl_t ctl,
    input  tta_pkg::sample_t   sample,
    input  tta_pkg::cfg_t      cfg,
    output logic               busy,
    output logic               res_valid,
    output tta_pkg::result_t   result
);
    import tta_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_NUM, S_DEN, S_NORM, S_SQ, S_LN, S_DD, S_N1, S_N2,
        S_TDIV, S_ACC, S_MEAN, S_MDIV, S_DONE
    } state_t;

    function automatic logic signed [15:0] sat16(input logic signed [SUM_WIDTH:0] v);
        logic signed [15:0] r;
        if (v > SUM_WIDTH'(32767)) r = T_MAX;
        else if (v < -(SUM_WIDTH+1)'(32768)) r = T_MIN;
        else r = v[15:0];
        return r;
    endfunction

    state_t                 state_reg, state_next;
    logic                   chan_reg, chan_next;
    logic                   which_reg, which_next;
    logic [12:0]            pv_reg, pv_next, tv_reg, tv_next;
    logic                   fault_reg, fault_next;
    logic [33:0]            x_reg, x_next;
    logic signed [6:0]      e_reg, e_next;
    logic [31:0]            m_reg, m_next;
    logic [4:0]             it_reg, it_next;
    logic [23:0]            frac_reg, frac_next;
    logic [29:0]            lgn_reg, lgn_next, lgd_reg, lgd_next;
    logic [29:0]            lnm_reg, lnm_next;
    logic                   neg_reg, neg_next;
    logic signed [48:0]     dd_reg, dd_next;
    logic [29:0]            tb_reg, tb_next;
    logic signed [15:0]     temp_reg, temp_next;
    logic signed [SUM_WIDTH-1:0] psum_reg, psum_next, tsum_reg, tsum_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic signed [15:0]     pavg_reg, pavg_next, tavg_reg, tavg_next;
    logic                   sneg_reg, sneg_next;
    logic                   rv_reg, rv_next;
    result_t                res_reg, res_next;

    logic [31:0]            mul_a, mul_b;
    logic [63:0]            prod;
    logic [12:0]            v_cur;
    logic [33:0]            sq;
    logic signed [30:0]     dlog;
    logic [29:0]            mag;
    logic [63:0]            lnr;
    logic [44:0]            base;
    logic                   div_start, div_done;
    logic [DVD_W-1:0]       div_dvd, div_q;
    logic [DVS_W-1:0]       div_dvs;
    logic signed [SUM_WIDTH-1:0] sum_cur;
    logic [SUM_WIDTH-1:0]   sum_mag;
    logic signed [SUM_WIDTH:0]   sum_wide, mean_s, off_s;
    logic signed [42:0]     tk_s;
    logic signed [15:0]     avg_v;
    logic                   good;

    // shared multiplier
    assign prod = mul_a * mul_b;

    tta_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    assign v_cur   = chan_reg ? tv_reg : pv_reg;
    assign sum_cur = chan_reg ? tsum_reg : psum_reg;

    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        which_next = which_reg;
        pv_next    = pv_reg;
        tv_next    = tv_reg;
        fault_next = fault_reg;
        x_next     = x_reg;
        e_next     = e_reg;
        m_next     = m_reg;
        it_next    = it_reg;
        frac_next  = frac_reg;
        lgn_next   = lgn_reg;
        lgd_next   = lgd_reg;
        lnm_next   = lnm_reg;
        neg_next   = neg_reg;
        dd_next    = dd_reg;
        tb_next    = tb_reg;
        temp_next  = temp_reg;
        psum_next  = psum_reg;
        tsum_next  = tsum_reg;
        cnt_next   = cnt_reg;
        pavg_next  = pavg_reg;
        tavg_next  = tavg_reg;
        sneg_next  = sneg_reg;
        rv_next    = 1'b0;
        res_next   = res_reg;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_dvd    = '0;
        div_dvs    = '0;
        sq         = prod[63:30];
        dlog       = $signed({1'b0, lgn_reg}) - $signed({1'b0, lgd_reg});
        mag        = dlog[30] ? 30'(-dlog) : dlog[29:0];
        lnr        = prod + (64'd1 << 29);
        base       = {21'(cfg.beta_kelvin) * 21'd100, 24'd0};
        sum_mag    = sum_cur[SUM_WIDTH-1] ? SUM_WIDTH'(-sum_cur) : SUM_WIDTH'(sum_cur);
        sum_wide   = '0;
        mean_s     = '0;
        off_s      = '0;
        tk_s       = '0;
        avg_v      = '0;
        good       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    pv_next    = sample.probe_mv;
                    tv_next    = sample.therm_mv;
                    fault_next = (sample.probe_mv == '0) || (sample.therm_mv == '0) ||
                                 (sample.probe_mv >= cfg.supply_mv) ||
                                 (sample.therm_mv >= cfg.supply_mv);
                    chan_next  = 1'b0;
                    if (fault_next || (cnt_reg == '1))
                        state_next = S_MEAN;
                    else
                        state_next = S_NUM;
                end
            end
            // numerator resistance term
            S_NUM:
            begin
                mul_a      = {12'd0, cfg.divider_ohms};
                mul_b      = {19'd0, 13'(cfg.supply_mv - v_cur)};
                x_next     = prod[33:0];
                e_next     = 7'sd30;
                which_next = 1'b0;
                state_next = S_NORM;
            end
            // denominator resistance term
            S_DEN:
            begin
                mul_a      = {19'd0, v_cur};
                mul_b      = {12'd0, cfg.nominal_ohms};
                x_next     = prod[33:0];
                e_next     = 7'sd30;
                which_next = 1'b1;
                state_next = S_NORM;
            end
            // bring the top set bit to bit 30, one place a cycle
            S_NORM:
            begin
                if (x_reg[33:31] != 3'd0)
                begin
                    x_next = x_reg >> 1;
                    e_next = e_reg + 7'sd1;
                end
                else if (!x_reg[30])
                begin
                    x_next = x_reg << 1;
                    e_next = e_reg - 7'sd1;
                end
                else
                begin
                    m_next     = x_reg[31:0];
                    frac_next  = '0;
                    it_next    = '0;
                    state_next = S_SQ;
                end
            end
            // one fraction bit per squaring
            S_SQ:
            begin
                mul_a     = m_reg;
                mul_b     = m_reg;
                m_next    = sq[31] ? {1'b0, sq[31:1]} : sq[31:0];
                frac_next = {frac_reg[22:0], sq[31]};
                it_next   = it_reg + 5'd1;
                if (it_reg == 5'd23)
                begin
                    if (which_reg)
                    begin
                        lgd_next   = {e_reg[5:0], frac_next};
                        state_next = S_LN;
                    end
                    else
                    begin
                        lgn_next   = {e_reg[5:0], frac_next};
                        state_next = S_DEN;
                    end
                end
            end
            // natural log from the log2 difference
            S_LN:
            begin
                mul_a      = {2'd0, mag};
                mul_b      = {2'd0, LN2_Q30};
                lnm_next   = lnr[59:30];
                neg_next   = dlog[30];
                state_next = S_DD;
            end
            S_DD:
            begin
                mul_a = {16'd0, cfg.nominal_temp_centik};
                mul_b = {2'd0, lnm_reg};
                if (neg_reg)
                    dd_next = $signed({4'd0, base}) - $signed({3'd0, prod[45:0]});
                else
                    dd_next = $signed({4'd0, base}) + $signed({3'd0, prod[45:0]});
                state_next = S_N1;
            end
            S_N1:
            begin
                mul_a   = {16'd0, cfg.nominal_temp_centik};
                mul_b   = {18'd0, cfg.beta_kelvin};
                tb_next = prod[29:0];
                if (dd_reg <= 0)
                begin
                    temp_next  = T_MAX;
                    state_next = S_ACC;
                end
                else
                    state_next = S_N2;
            end
            S_N2:
            begin
                mul_a      = {2'd0, tb_reg};
                mul_b      = 32'd100;
                div_start  = 1'b1;
                div_dvd    = {3'd0, prod[36:0], 24'd0} + 64'(dd_reg[47:1]);
                div_dvs    = dd_reg[47:0];
                state_next = S_TDIV;
            end
            // kelvin to celsius with clamp
            S_TDIV:
            begin
                if (div_done)
                begin
                    if (div_q > (64'd1 << 40))
                        temp_next = T_MAX;
                    else
                    begin
                        tk_s = $signed({2'd0, div_q[40:0]}) - $signed({28'd0, KELVIN_OFFSET});
                        temp_next = sat16((SUM_WIDTH+1)'(tk_s));
                    end
                    state_next = S_ACC;
                end
            end
            // saturating accumulate
            S_ACC:
            begin
                sum_wide = $signed({sum_cur[SUM_WIDTH-1], sum_cur}) +
                           (SUM_WIDTH+1)'(temp_reg);
                if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1])
                    sum_wide = sum_wide[SUM_WIDTH]
                        ? $signed({2'b11, {(SUM_WIDTH-1){1'b0}}})
                        : $signed({2'b00, {(SUM_WIDTH-1){1'b1}}});
                if (chan_reg)
                begin
                    tsum_next  = sum_wide[SUM_WIDTH-1:0];
                    cnt_next   = cnt_reg + 1'b1;
                    chan_next  = 1'b0;
                    state_next = S_MEAN;
                end
                else
                begin
                    psum_next  = sum_wide[SUM_WIDTH-1:0];
                    chan_next  = 1'b1;
                    state_next = S_NUM;
                end
            end
            // cumulative mean, rounded half away from zero
            S_MEAN:
            begin
                if (cnt_reg == '0)
                begin
                    avg_v = 16'(cfg.calib_offset_centic);
                    if (chan_reg)
                    begin
                        tavg_next  = avg_v;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pavg_next = avg_v;
                        chan_next = 1'b1;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    div_dvd    = 64'(sum_mag) + 64'(cnt_reg >> 1);
                    div_dvs    = DVS_W'(cnt_reg);
                    sneg_next  = sum_cur[SUM_WIDTH-1];
                    state_next = S_MDIV;
                end
            end
            S_MDIV:
            begin
                if (div_done)
                begin
                    mean_s = $signed({1'b0, div_q[SUM_WIDTH-1:0]});
                    if (sneg_reg)
                        mean_s = -mean_s;
                    off_s = (SUM_WIDTH+1)'(sat16(mean_s)) +
                            (SUM_WIDTH+1)'(cfg.calib_offset_centic);
                    avg_v = sat16(off_s);
                    if (chan_reg)
                    begin
                        tavg_next  = avg_v;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pavg_next  = avg_v;
                        chan_next  = 1'b1;
                        state_next = S_MEAN;
                    end
                end
            end
            // window check and hand-off to the output register
            S_DONE:
            begin
                good = (pavg_reg < cfg.upper_limit_centic) &&
                       (pavg_reg >= cfg.lower_limit_centic) &&
                       (tavg_reg < cfg.upper_limit_centic) &&
                       (tavg_reg >= cfg.lower_limit_centic);
                if (ctl.res_free)
                begin
                    res_next.probe_avg_centic = pavg_reg;
                    res_next.therm_avg_centic = tavg_reg;
                    res_next.bad_temp         = !good;
                    res_next.sample_fault     = fault_reg;
                    rv_next    = 1'b1;
                    chan_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            chan_reg  <= 1'b0;
            psum_reg  <= '0;
            tsum_reg  <= '0;
            cnt_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            psum_reg  <= psum_next;
            tsum_reg  <= tsum_next;
            cnt_reg   <= cnt_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        which_reg <= which_next;
        pv_reg    <= pv_next;
        tv_reg    <= tv_next;
        fault_reg <= fault_next;
        x_reg     <= x_next;
        e_reg     <= e_next;
        m_reg     <= m_next;
        it_reg    <= it_next;
        frac_reg  <= frac_next;
        lgn_reg   <= lgn_next;
        lgd_reg   <= lgd_next;
        lnm_reg   <= lnm_next;
        neg_reg   <= neg_next;
        dd_reg    <= dd_next;
        tb_reg    <= tb_next;
        temp_reg  <= temp_next;
        pavg_reg  <= pavg_next;
        tavg_reg  <= tavg_next;
        sneg_reg  <= sneg_next;
        res_reg   <= res_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = rv_reg;
    assign result    = res_reg;

endmodule

### rtl/thermistor_temperature_averager_top.sv
// channel   | handshake              | payload
// sample    | sample_valid/stall     | probe_mv, therm_mv
// result    | result_valid/stall     | two averages, bad_temp, sample_fault
// config    | cfg_write_en           | cfg_index, cfg_data
// A good item takes per channel two log2 passes (normalize, 24 squarings)
// and one division, then one division per mean.
// A faulted item or a full count skips to the two means, with no division at count zero.
// Reset clears sums and count and restores the configuration defaults;
// sample_stall stays high until the result register can take the item.
module thermistor_temperature_averager_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  tta_pkg::sample_t sample,
    output logic             result_valid,
    input  logic             result_stall,
    output tta_pkg::result_t result,
    input  logic             cfg_write_en,
    input  logic [2:0]       cfg_index,
    input  logic [19:0]      cfg_data
);
    import tta_pkg::*;

    logic [19:0]        div_ohms_reg, nom_ohms_reg;
    logic [13:0]        beta_reg;
    logic [15:0]        t0_reg;
    logic [12:0]        supply_reg;
    logic signed [13:0] offset_reg;
    logic signed [15:0] upper_reg, lower_reg;
    logic               rvalid_reg, rvalid_next;
    result_t            result_reg;
    cfg_t               cfg;
    core_ctl_t          ctl;
    logic               core_busy, core_valid;
    result_t            core_result;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_ohms_reg <= 20'd10000;
            nom_ohms_reg <= 20'd10000;
            beta_reg     <= 14'd3435;
            t0_reg       <= 16'd29815;
            supply_reg   <= 13'd5000;
            offset_reg   <= 14'sd900;
            upper_reg    <= 16'sd2000;
            lower_reg    <= 16'sd1000;
        end
        else if (cfg_write_en)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_DIVIDER_OHMS: div_ohms_reg <= cfg_data;
                REG_NOMINAL_OHMS: nom_ohms_reg <= cfg_data;
                REG_BETA_KELVIN:  beta_reg     <= cfg_data[13:0];
                REG_NOMINAL_TEMP: t0_reg       <= cfg_data[15:0];
                REG_SUPPLY_MV:    supply_reg   <= cfg_data[12:0];
                REG_CALIB_OFFSET: offset_reg   <= cfg_data[13:0];
                REG_UPPER_LIMIT:  upper_reg    <= cfg_data[15:0];
                REG_LOWER_LIMIT:  lower_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // zero in a scale register reads as one
    always_comb
    begin
        cfg.divider_ohms        = (div_ohms_reg == '0) ? 20'd1 : div_ohms_reg;
        cfg.nominal_ohms        = (nom_ohms_reg == '0) ? 20'd1 : nom_ohms_reg;
        cfg.beta_kelvin         = (beta_reg == '0) ? 14'd1 : beta_reg;
        cfg.nominal_temp_centik = (t0_reg == '0) ? 16'd1 : t0_reg;
        cfg.supply_mv           = supply_reg;
        cfg.calib_offset_centic = offset_reg;
        cfg.upper_limit_centic  = upper_reg;
        cfg.lower_limit_centic  = lower_reg;
    end

    assign sample_stall = core_busy;
    assign ctl.start    = sample_valid && !core_busy;
    assign ctl.res_free = !rvalid_reg || !result_stall;

    tta_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sample    (sample),
        .cfg       (cfg),
        .busy      (core_busy),
        .res_valid (core_valid),
        .result    (core_result)
    );

    // output register
    always_comb
    begin
        rvalid_next = rvalid_reg;
        if (core_valid)
            rvalid_next = 1'b1;
        else if (!result_stall)
            rvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rvalid_reg <= 1'b0;
        else
            rvalid_reg <= rvalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (core_valid)
            result_reg <= core_result;
    end

    assign result_valid = rvalid_reg;
    assign result       = result_reg;

endmodule

### rtl/tta_checker.sv
// port-level checks of the thermistor temperature averager
// depends on tta_pkg and the assertion macro header
`include "thermistor_temperature_averager_top_macros.svh"

module tta_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             sample_valid,
    input logic             sample_stall,
    input tta_pkg::sample_t sample,
    input logic             result_valid,
    input logic             result_stall,
    input tta_pkg::result_t result
);
    import tta_pkg::*;

    // a stalled result item stays offered
    `TTA_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid, "result dropped while stalled")
    // an accepted item keeps the block busy
    `TTA_ASSERT_NEXT(a_busy_after_accept, sample_valid && !sample_stall, sample_stall, "block ready right after taking an item")
    // no second result directly after one is taken
    `TTA_ASSERT_NEXT(a_single_result, result_valid && !result_stall, !result_valid, "result repeated")
    // a stalled result item keeps its payload
    `TTA_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(result), "result changed while stalled")

endmodule

bind thermistor_temperature_averager_top tta_checker u_tta_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

### tb/tb.sv
// testbench of the thermistor temperature averager: random and directed samples,
// configuration phases, cycle-free predictor checked item by item
// depends on tta_pkg and thermistor_temperature_averager_top
module tb;
    import tta_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_stall;
    sample_t     sample;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        cfg_write_en;
    logic [2:0]  cfg_index;
    logic [19:0] cfg_data;

    int          error_count;

    // configuration copy held by the predictor
    logic [19:0] divider_r, nominal_r;
    logic [13:0] beta_r;
    logic [15:0] t0_r;
    logic [12:0] supply_r;
    logic signed [13:0] offset_r;
    logic signed [15:0] upper_r, lower_r;

    // accumulator copy
    longint      probe_acc, therm_acc;
    longint unsigned sample_total;

    thermistor_temperature_averager_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    task automatic report(input string what);
        error_count++;
        $display("mismatch: %s", what);
    endtask

    // log2 in q24 by repeated squaring
    function automatic longint log2_q24(input longint unsigned n);
        int unsigned e;
        longint unsigned m;
        longint r;
        e = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (n[i])
            begin
                e = i;
            end
        end
        m = (e <= 30) ? (n << (30 - e)) : (n >> (e - 30));
        r = longint'(e) << 24;
        for (int i = 23; i >= 0; i--)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                r = r | (64'sd1 << i);
            end
        end
        return r;
    endfunction

    function automatic longint clamp16(input longint v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32768)
        begin
            return -32768;
        end
        return v;
    endfunction

    function automatic longint unsigned nz(input longint unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    // beta equation temperature in hundredths of a degree
    function automatic longint beta_temp(input longint unsigned v);
        longint unsigned num, den, b, t0, mag, lnm, n, tk;
        longint d, ln, dd;
        num = nz(divider_r) * (longint'(supply_r) - v);
        den = v * nz(nominal_r);
        b = nz(beta_r);
        t0 = nz(t0_r);
        d = log2_q24(num) - log2_q24(den);
        mag = (d < 0) ? -d : d;
        lnm = (mag * 744261118 + (64'd1 << 29)) >> 30;
        ln = (d < 0) ? -longint'(lnm) : longint'(lnm);
        dd = longint'((100 * b) << 24) + longint'(t0) * ln;
        if (dd <= 0)
        begin
            return 32767;
        end
        n = (100 * t0 * b) << 24;
        tk = (n + longint'(dd) / 2) / dd;
        if (tk > (64'd1 << 40))
        begin
            return 32767;
        end
        return clamp16(longint'(tk) - 27315);
    endfunction

    function automatic longint sum_sat(input longint s, input longint t);
        longint mx, mn;
        mx = (64'sd1 <<< (SUM_WIDTH - 1)) - 1;
        mn = -mx - 1;
        if (t > 0 && s > mx - t)
        begin
            return mx;
        end
        if (t < 0 && s < mn - t)
        begin
            return mn;
        end
        return s + t;
    endfunction

    function automatic longint mean_with_offset(input longint s);
        longint q;
        longint unsigned a, r;
        q = 0;
        if (sample_total != 0)
        begin
            a = (s < 0) ? -s : s;
            r = (a + sample_total / 2) / sample_total;
            q = (s < 0) ? -longint'(r) : longint'(r);
        end
        return clamp16(clamp16(q) + longint'(offset_r));
    endfunction

    // expected averages for one accepted sample
    function automatic result_t predict_averages(input sample_t s);
        result_t o;
        logic fault;
        longint pa, ta;
        longint unsigned cmax;
        cmax = (64'd1 << COUNT_WIDTH) - 1;
        fault = s.probe_mv == 0 || s.therm_mv == 0 || s.probe_mv >= supply_r
                || s.therm_mv >= supply_r;
        if (!fault && sample_total < cmax)
        begin
            probe_acc = sum_sat(probe_acc, beta_temp(s.probe_mv));
            therm_acc = sum_sat(therm_acc, beta_temp(s.therm_mv));
            sample_total++;
        end
        pa = mean_with_offset(probe_acc);
        ta = mean_with_offset(therm_acc);
        o.probe_avg_centic = pa[15:0];
        o.therm_avg_centic = ta[15:0];
        o.bad_temp = !(pa < upper_r && pa >= lower_r && ta < upper_r && ta >= lower_r);
        o.sample_fault = fault;
        return o;
    endfunction

    class average_scoreboard;
        result_t pending[$];

        function void note_sample(input sample_t s);
            pending.push_back(predict_averages(s));
        endfunction

        task check_result(input result_t r);
            result_t e;
            if (pending.size() == 0)
            begin
                report("result with nothing pending");
                return;
            end
            e = pending.pop_front();
            if (r.probe_avg_centic !== e.probe_avg_centic)
            begin
                report($sformatf("probe avg %0d want %0d", r.probe_avg_centic,
                                 e.probe_avg_centic));
            end
            if (r.therm_avg_centic !== e.therm_avg_centic)
            begin
                report($sformatf("therm avg %0d want %0d", r.therm_avg_centic,
                                 e.therm_avg_centic));
            end
            if (r.bad_temp !== e.bad_temp)
            begin
                report($sformatf("bad_temp %b want %b", r.bad_temp, e.bad_temp));
            end
            if (r.sample_fault !== e.sample_fault)
            begin
                report($sformatf("sample_fault %b want %b", r.sample_fault,
                                 e.sample_fault));
            end
        endtask
    endclass

    average_scoreboard board;
    bit stall_on;

    // clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #60000000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
        begin
            return $urandom_range(20, 200);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    // result side: random stall, check each accepted item
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                board.check_result(result);
            end
            if (stall_on)
            begin
                result_stall <= ($urandom_range(0, 3) == 0) ||
                                ($urandom_range(0, 60) == 0);
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // valid drops only ahead of a gap, so it gets one assignment per edge
    task automatic send_sample(input logic [12:0] p, input logic [12:0] t);
        sample_t s;
        int g;
        g = gap_len();
        if (g > 0)
        begin
            sample_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s.probe_mv = p;
        s.therm_mv = t;
        sample_valid <= 1'b1;
        sample <= s;
        do
        begin
            @(posedge clk);
        end
        while (sample_stall);
        board.note_sample(s);
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        while (board.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (600) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [19:0] v);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_DIVIDER_OHMS: divider_r = v;
            REG_NOMINAL_OHMS: nominal_r = v;
            REG_BETA_KELVIN:  beta_r = v[13:0];
            REG_NOMINAL_TEMP: t0_r = v[15:0];
            REG_SUPPLY_MV:    supply_r = v[12:0];
            REG_CALIB_OFFSET: offset_r = v[13:0];
            REG_UPPER_LIMIT:  upper_r = v[15:0];
            REG_LOWER_LIMIT:  lower_r = v[15:0];
            default: ;
        endcase
    endtask

    // mostly in-range voltages, some faults and extremes
    task automatic random_sample();
        logic [12:0] p, t;
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)
        begin
            p = 13'($urandom);
            t = 13'($urandom);
        end
        else if (k == 1)
        begin
            p = (supply_r > 1) ? 13'($urandom_range(1, supply_r - 1)) : 13'd1;
            t = $urandom_range(0, 1) ? 13'd0 : supply_r;
        end
        else if (supply_r > 1)
        begin
            p = 13'($urandom_range(1, supply_r - 1));
            t = 13'($urandom_range(1, supply_r - 1));
        end
        else
        begin
            p = 13'($urandom);
            t = 13'($urandom);
        end
        send_sample(p, t);
    endtask

    task automatic random_config();
        write_reg(REG_DIVIDER_OHMS,
                  $urandom_range(0, 3) == 0 ? 20'd1 : 20'($urandom_range(1, 1000000)));
        write_reg(REG_NOMINAL_OHMS, 20'($urandom_range(1, 1000000)));
        write_reg(REG_BETA_KELVIN, 20'($urandom_range(1000, 10000)));
        write_reg(REG_NOMINAL_TEMP, 20'($urandom_range(20000, 40000)));
        write_reg(REG_SUPPLY_MV,
                  $urandom_range(0, 3) == 0 ? 20'd8191 : 20'($urandom_range(2, 8191)));
        write_reg(REG_CALIB_OFFSET, 20'($signed($urandom_range(0, 10000)) - 5000));
        write_reg(REG_UPPER_LIMIT, 20'($signed($urandom_range(0, 25000)) - 5000));
        write_reg(REG_LOWER_LIMIT, 20'($signed($urandom_range(0, 25000)) - 5000));
    endtask

    // stimulus
    initial
    begin
        board = new();
        error_count = 0;
        stall_on = 1'b0;
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        cfg_write_en = 1'b0;
        cfg_index = REG_DIVIDER_OHMS;
        cfg_data = '0;
        divider_r = 10000;
        nominal_r = 10000;
        beta_r = 3435;
        t0_r = 29815;
        supply_r = 5000;
        offset_r = 900;
        upper_r = 2000;
        lower_r = 1000;
        probe_acc = 0;
        therm_acc = 0;
        sample_total = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty mean, faults, extremes
        send_sample(13'd0, 13'd2500);
        send_sample(13'd2500, 13'd5000);
        send_sample(13'd8191, 13'd8191);
        send_sample(13'd2500, 13'd2500);
        send_sample(13'd1, 13'd4999);
        send_sample(13'd4999, 13'd1);
        send_sample(13'd5000, 13'd0);
        send_sample(13'd1234, 13'd3777);
        stall_on = 1'b1;
        send_sample(13'd4096, 13'd2048);
        send_sample(13'd8191, 13'd1);
        drain();

        // zero registers read as one; extreme settings
        write_reg(REG_DIVIDER_OHMS, 20'd0);
        write_reg(REG_NOMINAL_OHMS, 20'd0);
        write_reg(REG_BETA_KELVIN, 20'd0);
        write_reg(REG_NOMINAL_TEMP, 20'd0);
        write_reg(REG_SUPPLY_MV, 20'd8191);
        write_reg(REG_CALIB_OFFSET, 20'(-5000));
        write_reg(REG_UPPER_LIMIT, 20'd20000);
        write_reg(REG_LOWER_LIMIT, 20'(-5000));
        send_sample(13'd1, 13'd8190);
        send_sample(13'd4095, 13'd6000);
        send_sample(13'd8190, 13'd1);
        drain();
        write_reg(REG_DIVIDER_OHMS, 20'd1000000);
        write_reg(REG_NOMINAL_OHMS, 20'd1);
        write_reg(REG_BETA_KELVIN, 20'd10000);
        write_reg(REG_NOMINAL_TEMP, 20'd40000);
        write_reg(REG_CALIB_OFFSET, 20'd5000);
        write_reg(REG_UPPER_LIMIT, 20'(-5000));
        write_reg(REG_LOWER_LIMIT, 20'd20000);
        send_sample(13'd1, 13'd8190);
        send_sample(13'd100, 13'd7000);
        drain();
        write_reg(REG_SUPPLY_MV, 20'd1);
        send_sample(13'd1, 13'd1);
        send_sample(13'd0, 13'd0);
        drain();

        // random phases with different settings
        for (int ph = 0; ph < 12; ph++)
        begin
            random_config();
            stall_on = (ph % 3) != 2;
            for (int i = 0; i < 150; i++)
            begin
                random_sample();
            end
            drain();
        end

        stall_on = 1'b0;
        drain();
        if (error_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/tta_pkg.sv
rtl/tta_div.sv
rtl/tta_core.sv
rtl/thermistor_temperature_averager_top.sv
rtl/tta_checker.sv
tb/tb.sv
